// ----- hw/rtl/rdbs_pkg.sv -----
// types and constants for the regex delimiter boundary scanner
package rdbs_pkg;

  localparam int CharWidth = 21;
  localparam int CodeWidth = 3;
  localparam int QueueDepth = 4;
  localparam int QueuePtrWidth = $clog2(QueueDepth);
  localparam int QueueCntWidth = $clog2(QueueDepth + 1);

  localparam logic [CharWidth-1:0] CH_BACKSLASH = 21'h00005C;
  localparam logic [CharWidth-1:0] CH_LBRACKET = 21'h00005B;
  localparam logic [CharWidth-1:0] CH_CARET = 21'h00005E;
  localparam logic [CharWidth-1:0] CH_RBRACKET = 21'h00005D;
  localparam logic [CharWidth-1:0] CH_PERIOD = 21'h00002E;
  localparam logic [CharWidth-1:0] CH_EQUAL = 21'h00003D;
  localparam logic [CharWidth-1:0] CH_COLON = 21'h00003A;
  localparam logic [CharWidth-1:0] CH_CR = 21'h00000D;
  localparam logic [CharWidth-1:0] CH_LF = 21'h00000A;
  localparam logic [CharWidth-1:0] CH_NONE = 21'h000000;
  localparam logic [CharWidth-1:0] DELIMITER_RESET = 21'h00002F;

  localparam logic [CodeWidth-1:0] CODE_CONTENT = 3'd0;
  localparam logic [CodeWidth-1:0] CODE_END_DELIM = 3'd1;
  localparam logic [CodeWidth-1:0] CODE_END_DELIM_EMPTY = 3'd2;
  localparam logic [CodeWidth-1:0] CODE_END_UNTERM = 3'd3;
  localparam logic [CodeWidth-1:0] CODE_END_UNTERM_EMPTY = 3'd4;

  typedef enum logic [3:0] {
    BS_OUTSIDE,
    BS_ESCAPED,
    BS_BR_FIRST,
    BS_BR_AFTER_CARET,
    BS_BR_BODY,
    BS_BR_AFTER_OPEN,
    BS_BR_PERIOD,
    BS_BR_PERIOD_END,
    BS_BR_EQUAL,
    BS_BR_EQUAL_END,
    BS_BR_COLON,
    BS_BR_COLON_END
  } bs_t;

  typedef struct packed {
    logic [CharWidth-1:0] character;
    logic                 end_of_input;
  } in_t;

  typedef struct packed {
    logic [CodeWidth-1:0] code;
    logic [CharWidth-1:0] reported_character;
    logic                 last;
  } out_t;

  typedef struct packed {
    logic                 has_res;
    logic [CodeWidth-1:0] code;
    logic [CharWidth-1:0] ch;
    bs_t                  state;
    logic                 any_content;
    logic                 held_cr;
  } step_t;

endpackage

// ----- hw/rtl/regex_delimiter_boundary_scanner_core.sv -----
// regex delimiter boundary scanner: classifies one character per beat
//
// Each accepted beat is classified combinationally: the boundary state, the
// content flag and the held CR flag update at the accepting edge, and the
// results go into a four-entry output queue. A beat gives zero, one or two
// result beats; two arise only when a held CR is released together with the
// following character. The input is ready whenever the queue has two free
// entries, so with the output side taking a beat every cycle the block
// sustains one character per cycle, and the queue absorbs the extra output
// beat of a two-result beat. The delimiter register may only be written
// while no scan results are outstanding.
module regex_delimiter_boundary_scanner_core
  import rdbs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_write,
  input  logic [CharWidth-1:0] cfg_data
);

  logic [CharWidth-1:0]     delimiter;
  bs_t                      state;
  bs_t                      state_next;
  logic                     any_content;
  logic                     any_content_next;
  logic                     held_cr;
  logic                     held_cr_next;

  out_t                     queue [QueueDepth];
  logic [QueuePtrWidth-1:0] wr_ptr;
  logic [QueuePtrWidth-1:0] rd_ptr;
  logic [QueueCntWidth-1:0] count;

  logic                     in_fire;
  logic                     out_fire;
  logic [1:0]               n_res;
  out_t                     res0;
  out_t                     res1;
  bs_t                      s_clean;
  step_t                    plain_now;
  step_t                    plain_after_cr;

  function automatic bs_t after_ordinary(bs_t s);
    bs_t r;
    unique case (s) inside
      BS_ESCAPED:        r = BS_OUTSIDE;
      BS_BR_FIRST,
      BS_BR_AFTER_CARET,
      BS_BR_AFTER_OPEN:  r = BS_BR_BODY;
      BS_BR_PERIOD_END:  r = BS_BR_PERIOD;
      BS_BR_EQUAL_END:   r = BS_BR_EQUAL;
      BS_BR_COLON_END:   r = BS_BR_COLON;
      default:           r = s;
    endcase
    return r;
  endfunction

  function automatic bs_t body_next(logic [CharWidth-1:0] c);
    bs_t r;
    if (c == CH_RBRACKET) r = BS_OUTSIDE;
    else if (c == CH_LBRACKET) r = BS_BR_AFTER_OPEN;
    else r = BS_BR_BODY;
    return r;
  endfunction

  function automatic bs_t next_state(bs_t s, logic [CharWidth-1:0] c);
    bs_t r;
    unique case (s) inside
      BS_ESCAPED: r = BS_OUTSIDE;
      BS_BR_FIRST: begin
        if (c == CH_CARET) r = BS_BR_AFTER_CARET;
        else if (c == CH_LBRACKET) r = BS_BR_AFTER_OPEN;
        else r = BS_BR_BODY;
      end
      BS_BR_AFTER_CARET: r = (c == CH_LBRACKET) ? BS_BR_AFTER_OPEN : BS_BR_BODY;
      BS_BR_BODY: r = body_next(c);
      BS_BR_AFTER_OPEN: begin
        if (c == CH_PERIOD) r = BS_BR_PERIOD;
        else if (c == CH_EQUAL) r = BS_BR_EQUAL;
        else if (c == CH_COLON) r = BS_BR_COLON;
        else r = body_next(c);
      end
      BS_BR_PERIOD,
      BS_BR_PERIOD_END: begin
        if (s == BS_BR_PERIOD_END && c == CH_RBRACKET) r = BS_BR_BODY;
        else r = (c == CH_PERIOD) ? BS_BR_PERIOD_END : BS_BR_PERIOD;
      end
      BS_BR_EQUAL,
      BS_BR_EQUAL_END: begin
        if (s == BS_BR_EQUAL_END && c == CH_RBRACKET) r = BS_BR_BODY;
        else r = (c == CH_EQUAL) ? BS_BR_EQUAL_END : BS_BR_EQUAL;
      end
      BS_BR_COLON,
      BS_BR_COLON_END: begin
        if (s == BS_BR_COLON_END && c == CH_RBRACKET) r = BS_BR_BODY;
        else r = (c == CH_COLON) ? BS_BR_COLON_END : BS_BR_COLON;
      end
      default: begin
        if (c == CH_BACKSLASH) r = BS_ESCAPED;
        else if (c == CH_LBRACKET) r = BS_BR_FIRST;
        else r = BS_OUTSIDE;
      end
    endcase
    return r;
  endfunction

  // one character with no CR held
  function automatic step_t plain_step(bs_t s, logic [CharWidth-1:0] c, logic eoi,
                                       logic anyc, logic [CharWidth-1:0] delim);
    step_t r;
    r.has_res     = 1'b1;
    r.code        = CODE_CONTENT;
    r.ch          = c;
    r.state       = BS_OUTSIDE;
    r.any_content = 1'b0;
    r.held_cr     = 1'b0;
    if (eoi) begin
      r.code = anyc ? CODE_END_UNTERM : CODE_END_UNTERM_EMPTY;
      r.ch   = CH_NONE;
    end else if (s == BS_OUTSIDE && c == delim) begin
      r.code = anyc ? CODE_END_DELIM : CODE_END_DELIM_EMPTY;
    end else if (c == CH_CR) begin
      r.has_res     = 1'b0;
      r.state       = s;
      r.any_content = anyc;
      r.held_cr     = 1'b1;
    end else if (c == CH_LF) begin
      if (s == BS_ESCAPED) begin
        r.any_content = 1'b1;
      end else begin
        r.code = anyc ? CODE_END_UNTERM : CODE_END_UNTERM_EMPTY;
      end
    end else begin
      r.state       = next_state(s, c);
      r.any_content = 1'b1;
    end
    return r;
  endfunction

  assign s_clean = (state > BS_BR_COLON_END) ? BS_OUTSIDE : state;

  assign plain_now = plain_step(s_clean, in_data.character, in_data.end_of_input,
                                any_content, delimiter);
  assign plain_after_cr = plain_step(after_ordinary(s_clean), in_data.character,
                                     in_data.end_of_input, 1'b1, delimiter);

  always_comb begin
    n_res            = 2'd0;
    res0             = '{code: CODE_CONTENT, reported_character: CH_CR, last: 1'b1};
    res1             = '{code: CODE_CONTENT, reported_character: CH_CR, last: 1'b1};
    state_next       = s_clean;
    any_content_next = any_content;
    held_cr_next     = held_cr;
    if (held_cr) begin
      if (!in_data.end_of_input && in_data.character == CH_LF && s_clean != BS_ESCAPED) begin
        // cr lf line end
        n_res            = 2'd1;
        res0.code        = any_content ? CODE_END_UNTERM : CODE_END_UNTERM_EMPTY;
        state_next       = BS_OUTSIDE;
        any_content_next = 1'b0;
        held_cr_next     = 1'b0;
      end else if (!in_data.end_of_input && in_data.character == CH_LF &&
                   delimiter != CH_CR) begin
        // escaped cr lf, both content
        n_res                   = 2'd2;
        res0.last               = 1'b0;
        res1.reported_character = CH_LF;
        state_next              = BS_OUTSIDE;
        any_content_next        = 1'b1;
        held_cr_next            = 1'b0;
      end else begin
        // release cr as content, then the new character
        state_next       = plain_after_cr.state;
        any_content_next = plain_after_cr.any_content;
        held_cr_next     = plain_after_cr.held_cr;
        if (plain_after_cr.has_res) begin
          n_res                   = 2'd2;
          res0.last               = 1'b0;
          res1.code               = plain_after_cr.code;
          res1.reported_character = plain_after_cr.ch;
        end else begin
          n_res = 2'd1;
        end
      end
    end else begin
      state_next       = plain_now.state;
      any_content_next = plain_now.any_content;
      held_cr_next     = plain_now.held_cr;
      n_res            = {1'b0, plain_now.has_res};
      res0.code               = plain_now.code;
      res0.reported_character = plain_now.ch;
    end
  end

  assign in_ready  = (count <= QueueCntWidth'(QueueDepth - 2));
  assign in_fire   = in_valid && in_ready;
  assign out_valid = (count != '0);
  assign out_fire  = out_valid && out_ready;
  assign out_data  = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter <= DELIMITER_RESET;
    end else if (cfg_write) begin
      delimiter <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= BS_OUTSIDE;
      any_content <= 1'b0;
      held_cr     <= 1'b0;
    end else if (in_fire) begin
      state       <= state_next;
      any_content <= any_content_next;
      held_cr     <= held_cr_next;
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (in_fire && n_res != 2'd0) begin
      queue[wr_ptr] <= res0;
    end
    if (in_fire && n_res == 2'd2) begin
      queue[wr_ptr + QueuePtrWidth'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (in_fire) begin
        wr_ptr <= wr_ptr + QueuePtrWidth'(n_res);
      end
      if (out_fire) begin
        rd_ptr <= rd_ptr + QueuePtrWidth'(1);
      end
      count <= count + (in_fire ? QueueCntWidth'(n_res) : '0)
                     - (out_fire ? QueueCntWidth'(1) : '0);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QueueCntWidth'(QueueDepth))
    else $error("result queue overfilled");

  a_pair_queued: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last |-> count >= QueueCntWidth'(2))
    else $error("first of a result pair without its partner");

  a_silent_holds_cr: assert property (@(posedge clk) disable iff (rst)
    in_fire && n_res == 2'd0 |=> held_cr)
    else $error("beat with no result did not hold a cr");
`endif

endmodule
